>>> rtl/core/lru_pkg.sv
// Shared types and constants of the block cache tag manager.
// Used by the controller, the datapath and the top level; no dependencies.
package lru_pkg;

  // Operation codes carried in func.
  localparam logic [2:0] FuncProbe = 3'd0;
  localparam logic [2:0] FuncTouch = 3'd1;
  localparam logic [2:0] FuncMerge = 3'd2;
  localparam logic [2:0] FuncInsert = 3'd3;
  localparam logic [2:0] FuncClean = 3'd4;
  localparam logic [2:0] FuncEvict = 3'd5;

  // Result status codes.
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusAbsent = 2'd1;
  localparam logic [1:0] StatusNoVictim = 2'd2;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StLookup = 6'b000010,
    StDecide = 6'b000100,
    StEvict  = 6'b001000,
    StApply  = 6'b010000,
    StOut    = 6'b100000
  } lru_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic lookup;   // register the key search and the LRU clean search
    logic evict;    // drop the registered LRU clean entry
    logic promote;  // move the hit entry to most recent
    logic set_dirty;
    logic clr_dirty;
    logic add;      // add the key dirty as most recent
  } lru_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic hit;
    logic clean_found;
    logic full;     // used count at or above the effective capacity
    logic empty;
  } lru_sts_t;

endpackage

>>> rtl/core/lru_datapath.sv
// Datapath of the block cache tag manager: entry store, recency ranks,
// key search and least recent clean search. Depends on lru_pkg.
module lru_datapath import lru_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int KEY_BITS = 32,
  parameter int CW = $clog2(ENTRIES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [CW-1:0]       cap_i,
  input  lru_cmd_t            cmd_i,
  output lru_sts_t            sts_o,
  output logic [CW-1:0]       used_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Leaves of the clean search tree, padded to a power of two.
  localparam int TN = 1 << IW;

  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [ENTRIES-1:0]   dirty_q, dirty_d;
  logic [KEY_BITS-1:0]  key_q [ENTRIES];
  logic [IW-1:0]        rank_q [ENTRIES];
  logic [IW-1:0]        rank_d [ENTRIES];
  logic [CW-1:0]        used_q, used_d;

  logic                 hit_q, clean_q;
  logic [IW-1:0]        hidx_q, cidx_q;
  logic [IW-1:0]        free_q;

  // Key match and free slot search; the lowest matching or free index wins.
  logic [ENTRIES-1:0]   match;
  logic [ENTRIES-1:0]   cand;
  logic                 any_hit, any_clean, any_free;
  logic [IW-1:0]        hidx, cidx, fidx;

  logic                 t_ok [2*TN];
  logic [IW-1:0]        t_idx [2*TN];
  logic [IW-1:0]        t_rank [2*TN];

  always_comb begin
    any_hit = 1'b0;
    hidx = '0;
    any_free = 1'b0;
    fidx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == key_i);
      cand[i] = valid_q[i] && !dirty_q[i];
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_hit = 1'b1;
        hidx = IW'(i);
      end
      if (!valid_q[i]) begin
        any_free = 1'b1;
        fidx = IW'(i);
      end
    end
  end

  // Least recent clean search as a balanced tree of compare and select
  // steps; on equal ranks the lower index is kept.
  always_comb begin
    for (int n = 0; n < 2 * TN; n++) begin
      t_ok[n] = 1'b0;
      t_idx[n] = '0;
      t_rank[n] = '0;
    end
    for (int i = 0; i < TN; i++) begin
      if (i < ENTRIES) begin
        t_ok[TN + i] = cand[i];
        t_rank[TN + i] = rank_q[i];
      end
      t_idx[TN + i] = IW'(i);
    end
    for (int n = TN - 1; n >= 1; n--) begin
      if (t_ok[2*n] && (!t_ok[2*n+1] || !(t_rank[2*n+1] < t_rank[2*n]))) begin
        t_ok[n] = 1'b1;
        t_idx[n] = t_idx[2*n];
        t_rank[n] = t_rank[2*n];
      end else begin
        t_ok[n] = t_ok[2*n+1];
        t_idx[n] = t_idx[2*n+1];
        t_rank[n] = t_rank[2*n+1];
      end
    end
    any_clean = t_ok[1];
    cidx = t_idx[1];
  end

  // Registered search results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      clean_q <= 1'b0;
    end else if (cmd_i.lookup || cmd_i.evict) begin
      if (cmd_i.lookup) hit_q <= any_hit;
      clean_q <= any_clean;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup || cmd_i.evict) begin
      if (cmd_i.lookup) hidx_q <= hidx;
      cidx_q <= cidx;
      free_q <= fidx;
    end
  end

  // Next state of the entry store.
  always_comb begin
    logic [IW-1:0] gap;
    gap = '0;
    valid_d = valid_q;
    dirty_d = dirty_q;
    used_d = used_q;
    for (int i = 0; i < ENTRIES; i++) rank_d[i] = rank_q[i];
    if (cmd_i.evict) begin
      gap = rank_q[cidx_q];
      valid_d[cidx_q] = 1'b0;
      dirty_d[cidx_q] = 1'b0;
      used_d = used_q - CW'(1);
      for (int i = 0; i < ENTRIES; i++)
        if (valid_q[i] && rank_q[i] > gap) rank_d[i] = rank_q[i] - IW'(1);
      rank_d[cidx_q] = '0;
    end else if (cmd_i.promote) begin
      gap = rank_q[hidx_q];
      for (int i = 0; i < ENTRIES; i++)
        if (valid_q[i] && rank_q[i] > gap) rank_d[i] = rank_q[i] - IW'(1);
      rank_d[hidx_q] = IW'(used_q - CW'(1));
      if (cmd_i.set_dirty) dirty_d[hidx_q] = 1'b1;
    end else if (cmd_i.clr_dirty) begin
      dirty_d[hidx_q] = 1'b0;
    end else if (cmd_i.add) begin
      valid_d[free_q] = 1'b1;
      dirty_d[free_q] = 1'b1;
      rank_d[free_q] = IW'(used_q);
      used_d = used_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      used_q <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      used_q <= used_d;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= rank_d[i];
    end
  end

  // Key store is written only when an entry is added.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add) key_q[free_q] <= key_i;
  end

  assign sts_o.hit = hit_q;
  assign sts_o.clean_found = clean_q;
  assign sts_o.full = (used_q >= cap_i);
  assign sts_o.empty = (used_q == '0);
  assign used_o = used_q;

  // An entry is only added while a free slot exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add |-> !valid_q[free_q])
    else $error("add into a valid slot");
  // Eviction only hits a clean valid entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> (valid_q[cidx_q] && !dirty_q[cidx_q]))
    else $error("evict of a dirty or empty entry");
  // Used count tracks the number of valid entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(used_q))
    else $error("used count out of step");

endmodule

>>> rtl/core/lru_ctrl.sv
// Controller of the block cache tag manager: sequences lookup, eviction,
// update and result beats. Depends on lru_pkg.
module lru_ctrl import lru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [6:0]  want_i,
  input  lru_sts_t    sts_i,
  output lru_cmd_t    cmd_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [1:0]  status_o,
  output logic [6:0]  evicted_o,
  output logic        flush_o
);

  lru_state_e state_q, state_d;
  logic [2:0] func_q;
  logic [6:0] want_q;
  logic [6:0] ev_q, ev_d;
  logic       hit_q, hit_d, flush_q, flush_d;
  logic [1:0] status_q, status_d;
  logic       is_add;

  assign in_ready_o = (state_q == StIdle);
  assign is_add = (func_q == FuncMerge) || (func_q == FuncInsert);

  // State sequencing and command decode. After each eviction the searches
  // are run again so that the next victim is taken from the updated store.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    ev_d = ev_q;
    hit_d = hit_q;
    flush_d = flush_q;
    status_d = status_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StLookup;
          ev_d = '0;
          flush_d = 1'b0;
          status_d = StatusOk;
        end
      end
      StLookup: begin
        cmd_o.lookup = 1'b1;
        state_d = StDecide;
      end
      StDecide: begin
        hit_d = (func_q != FuncEvict) && sts_i.hit;
        state_d = StApply;
        if (func_q == FuncEvict) begin
          // An evict on a cache that was empty at the start does nothing.
          if ((!sts_i.empty || ev_q != 7'd0) && (ev_q < want_q)) begin
            if (sts_i.clean_found) state_d = StEvict;
            else begin
              flush_d = 1'b1;
              state_d = StOut;
            end
          end else state_d = StOut;
        end else if (is_add && !sts_i.hit && sts_i.full) begin
          if (sts_i.clean_found) state_d = StEvict;
          else begin
            flush_d = 1'b1;
            status_d = StatusNoVictim;
            state_d = StOut;
          end
        end
      end
      StEvict: begin
        cmd_o.evict = 1'b1;
        ev_d = ev_q + 7'd1;
        state_d = StLookup;
      end
      StApply: begin
        state_d = StOut;
        case (func_q)
          FuncTouch: cmd_o.promote = sts_i.hit;
          FuncMerge, FuncInsert: begin
            if (sts_i.hit) begin
              cmd_o.promote = 1'b1;
              cmd_o.set_dirty = (func_q == FuncInsert);
            end else cmd_o.add = 1'b1;
          end
          FuncClean: begin
            if (sts_i.hit) cmd_o.clr_dirty = 1'b1;
            else status_d = StatusAbsent;
          end
          default: ;
        endcase
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ev_q <= '0;
      hit_q <= 1'b0;
      flush_q <= 1'b0;
      status_q <= StatusOk;
    end else begin
      state_q <= state_d;
      ev_q <= ev_d;
      hit_q <= hit_d;
      flush_q <= flush_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      want_q <= want_i;
    end
  end

  assign out_valid_o = (state_q == StOut);
  assign hit_o = hit_q;
  assign status_o = status_q;
  assign evicted_o = ev_q;
  assign flush_o = flush_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEvict) |=> (state_q == StLookup))
    else $error("evict not followed by lookup");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(ev_q))
    else $error("result changed while stalled");

endmodule

>>> rtl/core/lru_block_cache_tag_manager.sv
// Block cache tag manager: LRU tag store with dirty bits for a fully
// associative block cache. An input beat passes the lookup, decide,
// apply and result steps; evicts and adds with no clean victim skip
// apply, and each evicted entry adds evict, lookup and decide steps.
// A new beat is taken only when idle, after the result beat is taken.
// Reset (rst_ni, asynchronous) empties the cache and sets capacity to 64.
module lru_block_cache_tag_manager import lru_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // func[2:0], block_addr[34:3], evict_count[41:35]
  input  logic        s_axis_tlast,  // last_in_request
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // hit[0], status[2:1], evicted[9:3],
                                     // flush_request[10], occupancy[17:11]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(ENTRIES + 1);

  logic [6:0]    cap_q;
  logic [CW-1:0] cap_eff;
  lru_cmd_t      cmd;
  lru_sts_t      sts;
  logic [CW-1:0] used;
  logic          hit, flush;
  logic [1:0]    status;
  logic [6:0]    evicted;
  logic          unused_last;

  assign unused_last = s_axis_tlast;

  // Capacity register; only register 0 exists.
  assign pready = 1'b1;
  assign prdata = {25'd0, cap_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 7'd64;
    else if (psel && penable && pwrite && paddr == 1'b0) cap_q <= pwdata[6:0];
  end

  // Clamp capacity into 1..ENTRIES.
  always_comb begin
    if (cap_q == 7'd0) cap_eff = CW'(1);
    else if (int'(cap_q) > ENTRIES) cap_eff = CW'(ENTRIES);
    else cap_eff = CW'(cap_q);
  end

  lru_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tdata[2:0]),
    .want_i     (s_axis_tdata[41:35]),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .hit_o      (hit),
    .status_o   (status),
    .evicted_o  (evicted),
    .flush_o    (flush)
  );

  logic [KEY_BITS-1:0] key_hold_q;
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      key_hold_q <= KEY_BITS'({32'd0, s_axis_tdata[34:3]});
  end

  lru_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .CW(CW)) u_dp (
    .clk_i, .rst_ni,
    .key_i (key_hold_q),
    .cap_i (cap_eff),
    .cmd_i (cmd),
    .sts_o (sts),
    .used_o(used)
  );

  assign m_axis_tdata = {6'd0, 7'(used), flush, evicted, status, hit};

endmodule
